FILE: design/lrwm_pkg.sv
// Shared types and codes for the low-rank weight merge block.
package lrwm_pkg;

	localparam int VAL_W = 16;

	localparam logic [1:0] KIND_B    = 2'd0;
	localparam logic [1:0] KIND_A    = 2'd1;
	localparam logic [1:0] KIND_BASE = 2'd2;

	localparam logic [1:0] CFG_RANK  = 2'd0;
	localparam logic [1:0] CFG_SCALE = 2'd1;
	localparam logic [1:0] CFG_COLS  = 2'd2;
	localparam logic [1:0] CFG_ROWS  = 2'd3;

	typedef struct packed {
		logic [1:0]              kind;
		logic signed [VAL_W-1:0] value;
	} lrwm_in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] merged_weight;
		logic                    saturated;
		logic                    row_end;
		logic                    matrix_end;
	} lrwm_out_t;

endpackage

FILE: design/low_rank_weight_merge_core.sv
// Top level of the low-rank weight merge block.
// Items are taken one at a time. A B element is written to the B memory; an
// A element is scaled in a multiply register, then rounded and stored in its
// rank cell. For a base weight, the single read port of the B memory issues one
// rank term per cycle, and the running sum walks the row of rank cells one cell
// per cycle, then is rounded and handed to the output register. The output
// register lets the next item in while a result waits. The B memory needs no
// clearing after reset.
module low_rank_weight_merge_core
	import lrwm_pkg::*;
#(
	parameter int MAX_RANK    = 16,
	parameter int MAX_COLUMNS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  lrwm_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output lrwm_out_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int RIW    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int CIW    = $clog2(MAX_COLUMNS);
	localparam int B_DEPTH = MAX_RANK * MAX_COLUMNS;
	localparam int BAW    = $clog2(B_DEPTH);
	localparam int RCW    = (RIW + 1 > 5) ? RIW + 1 : 5;
	localparam int CCW    = (CIW + 1 > 11) ? CIW + 1 : 11;
	localparam int ACC_W  = 33 + $clog2(MAX_RANK + 1);
	localparam int SH_W   = ACC_W - 11;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_AWR  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [4:0]  rank_used_q;
	logic [15:0] scale_q;
	logic [10:0] cols_q;
	logic [15:0] rows_q;

	logic [1:0]  state_q;
	logic [BAW-1:0] b_idx_q;
	logic [RIW-1:0] a_idx_q;
	logic [CIW-1:0] col_idx_q;
	logic [15:0]    row_idx_q;

	logic [RCW-1:0] rank_wide;
	logic [RIW:0]   rank_eff;
	logic [CCW-1:0] cols_wide;
	logic [CIW:0]   cols_eff;
	logic [15:0]    rows_eff;
	logic [BAW:0]   b_lim;

	logic in_fire;
	logic rend;
	logic mend;

	logic signed [32:0] a_prod_q;
	logic [RIW-1:0]     a_wsel_q;
	logic signed [33:0] a_rnd;
	logic signed [25:0] a_sh;
	logic signed [VAL_W-1:0] a_sat;

	logic signed [VAL_W-1:0] base_q;
	logic rend_q;
	logic mend_q;
	logic [BAW-1:0] rd_addr_q;
	logic [RIW:0]   rd_cnt_q;
	logic           rd_issue;
	logic           head_tok_q;
	logic [VAL_W-1:0] b_rdata;
	logic             b_we;

	logic                    tok_o [MAX_RANK];
	logic signed [ACC_W-1:0] sum_o [MAX_RANK];
	logic [MAX_RANK-1:0]     tok_v;
	logic [MAX_RANK-1:0]     cell_en;
	logic [MAX_RANK-1:0]     cell_we;

	logic [RIW-1:0]          tap_sel;
	logic                    tap_tok;
	logic signed [ACC_W-1:0] tap_sum;
	logic signed [ACC_W:0]   w_rnd;
	logic signed [SH_W-1:0]  w_sh;
	lrwm_out_t               res_d;
	lrwm_out_t               res_q;
	lrwm_out_t               out_q;
	logic                    out_valid_q;

	// Effective configuration.
	always_comb begin
		rank_wide = RCW'(rank_used_q);
		if (rank_wide == '0) begin
			rank_eff = (RIW + 1)'(1);
		end else if (rank_wide > RCW'(MAX_RANK)) begin
			rank_eff = (RIW + 1)'(MAX_RANK);
		end else begin
			rank_eff = (RIW + 1)'(rank_wide);
		end
		cols_wide = CCW'(cols_q);
		if (cols_wide == '0) begin
			cols_eff = (CIW + 1)'(1);
		end else if (cols_wide > CCW'(MAX_COLUMNS)) begin
			cols_eff = (CIW + 1)'(MAX_COLUMNS);
		end else begin
			cols_eff = (CIW + 1)'(cols_wide);
		end
		rows_eff = (rows_q == '0) ? 16'd1 : rows_q;
		b_lim    = (BAW + 1)'(rank_eff * cols_eff);
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;

	assign rend = ((CIW + 1)'(col_idx_q) + (CIW + 1)'(1)) >= cols_eff;
	assign mend = rend && ((17'(row_idx_q) + 17'd1) >= 17'(rows_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_used_q <= 5'd1;
			scale_q     <= 16'd256;
			cols_q      <= 11'd1024;
			rows_q      <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RANK:  rank_used_q <= cfg_data[4:0];
				CFG_SCALE: scale_q     <= cfg_data;
				CFG_COLS:  cols_q      <= cfg_data[10:0];
				CFG_ROWS:  rows_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// A scaling: round half up to Q4.12 and clip.
	always_comb begin
		a_rnd = {a_prod_q[32], a_prod_q} + 34'sd128;
		a_sh  = 26'(a_rnd >>> 8);
		if (a_sh > 26'sd32767) begin
			a_sat = 16'sh7FFF;
		end else if (a_sh < -26'sd32768) begin
			a_sat = 16'sh8000;
		end else begin
			a_sat = VAL_W'(a_sh);
		end
	end

	assign b_we     = in_fire && (in_data.kind == KIND_B);
	assign rd_issue = (state_q == ST_RUN) && (rd_cnt_q < rank_eff);

	lrwm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(B_DEPTH)
	) u_b_store (
		.clk  (clk),
		.we   (b_we),
		.waddr(b_idx_q),
		.wdata(in_data.value),
		.re   (rd_issue),
		.raddr(rd_addr_q),
		.rdata(b_rdata)
	);

	genvar gi;
	generate
		for (gi = 0; gi < MAX_RANK; gi++) begin : g_cell
			assign cell_en[gi] = (RIW + 1)'(gi) < rank_eff;
			assign cell_we[gi] = (state_q == ST_AWR) && (a_wsel_q == RIW'(gi));
			assign tok_v[gi]   = tok_o[gi];
			if (gi == 0) begin : g_head
				lrwm_cell #(.ACC_W(ACC_W)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.en     (cell_en[gi]),
					.a_we   (cell_we[gi]),
					.a_wdata(a_sat),
					.b_data (signed'(b_rdata)),
					.tok_in (head_tok_q),
					.sum_in (ACC_W'(base_q) <<< 12),
					.tok_out(tok_o[gi]),
					.sum_out(sum_o[gi])
				);
			end else begin : g_link
				lrwm_cell #(.ACC_W(ACC_W)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.en     (cell_en[gi]),
					.a_we   (cell_we[gi]),
					.a_wdata(a_sat),
					.b_data (signed'(b_rdata)),
					.tok_in (tok_o[gi-1]),
					.sum_in (sum_o[gi-1]),
					.tok_out(tok_o[gi]),
					.sum_out(sum_o[gi])
				);
			end
		end
	endgenerate

	// Tap the last cell in use, round half up to Q4.12 and clip.
	always_comb begin
		tap_sel = RIW'(rank_eff - (RIW + 1)'(1));
		tap_tok = tok_o[tap_sel];
		tap_sum = sum_o[tap_sel];
		w_rnd   = {tap_sum[ACC_W-1], tap_sum} + (ACC_W + 1)'(2048);
		w_sh    = SH_W'(w_rnd >>> 12);
		res_d.row_end    = rend_q;
		res_d.matrix_end = mend_q;
		if (w_sh > SH_W'(32767)) begin
			res_d.merged_weight = 16'sh7FFF;
			res_d.saturated     = 1'b1;
		end else if (w_sh < SH_W'(-32768)) begin
			res_d.merged_weight = 16'sh8000;
			res_d.saturated     = 1'b1;
		end else begin
			res_d.merged_weight = VAL_W'(w_sh);
			res_d.saturated     = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_prod_q <= in_data.value * signed'({1'b0, scale_q});
			a_wsel_q <= a_idx_q;
			base_q   <= in_data.value;
			rend_q   <= rend;
			mend_q   <= mend;
		end
		if (in_fire) begin
			rd_addr_q <= BAW'(col_idx_q);
		end else if (rd_issue) begin
			rd_addr_q <= rd_addr_q + BAW'(cols_eff);
		end
		if (state_q == ST_RUN && tap_tok) begin
			res_q <= res_d;
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			b_idx_q     <= '0;
			a_idx_q     <= '0;
			col_idx_q   <= '0;
			row_idx_q   <= '0;
			rd_cnt_q    <= '0;
			head_tok_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			head_tok_q <= (state_q == ST_RUN) && (rd_cnt_q == '0);
			if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + (RIW + 1)'(1);
			end
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_data.kind)
							KIND_B: begin
								b_idx_q <= (((BAW + 1)'(b_idx_q) + (BAW + 1)'(1)) >= b_lim)
									? '0 : b_idx_q + BAW'(1);
							end
							KIND_A: begin
								a_idx_q <= (((RIW + 1)'(a_idx_q) + (RIW + 1)'(1)) >= rank_eff)
									? '0 : a_idx_q + RIW'(1);
								state_q <= ST_AWR;
							end
							KIND_BASE: begin
								rd_cnt_q <= '0;
								state_q  <= ST_RUN;
								if (rend) begin
									col_idx_q <= '0;
									a_idx_q   <= '0;
									if (mend) begin
										row_idx_q <= '0;
										b_idx_q   <= '0;
									end else begin
										row_idx_q <= row_idx_q + 16'd1;
									end
								end else begin
									col_idx_q <= col_idx_q + CIW'(1);
								end
							end
							default: ;
						endcase
					end
				end
				ST_AWR: begin
					state_q <= ST_IDLE;
				end
				ST_RUN: begin
					if (tap_tok) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_v, head_tok_q}))
		else $error("more than one sum in the cell chain");

	a_base_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.kind == KIND_BASE) |=> (state_q == ST_RUN))
		else $error("base weight did not start the chain");

	a_reads_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (rd_cnt_q <= rank_eff))
		else $error("B reads exceed rank");

	a_tap_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(tap_tok && state_q != ST_RUN) |-> 1'b0)
		else $error("sum left the chain outside a run");

endmodule

FILE: design/lrwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrwm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/lrwm_cell.sv
// One rank cell: holds a scaled A value and adds its product to the passing sum.
module lrwm_cell
	import lrwm_pkg::*;
#(
	parameter int ACC_W = 38
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     a_we,
	input  logic signed [VAL_W-1:0]  a_wdata,
	input  logic signed [VAL_W-1:0]  b_data,
	input  logic                     tok_in,
	input  logic signed [ACC_W-1:0]  sum_in,
	output logic                     tok_out,
	output logic signed [ACC_W-1:0]  sum_out
);

	logic signed [VAL_W-1:0]   a_q;
	logic signed [2*VAL_W-1:0] prod;
	logic                      tok_q;
	logic signed [ACC_W-1:0]   sum_q;

	assign prod = a_q * b_data;

	always_ff @(posedge clk) begin
		if (a_we) begin
			a_q <= a_wdata;
		end
		if (tok_in && en) begin
			sum_q <= sum_in + ACC_W'(prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in & en;
		end
	end

	assign tok_out = tok_q;
	assign sum_out = sum_q;

endmodule

FILE: tb/lrwm_merge_checker.sv
// Checker for the low-rank weight merge block: watches the three channels, predicts and compares.
module lrwm_merge_checker
	import lrwm_pkg::*;
#(
	parameter int MAX_RANK    = 16,
	parameter int MAX_COLUMNS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  lrwm_in_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  lrwm_out_t   out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          weights_checked,
	output int          clipped_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int B_DEPTH = MAX_RANK * MAX_COLUMNS;

	logic signed [VAL_W-1:0] b_mem [B_DEPTH];
	logic signed [VAL_W-1:0] a_cells [MAX_RANK];
	int b_ptr, a_ptr, col_pos, row_pos;
	int rank_reg, scale_reg, cols_reg, rows_reg;
	int n_bad, n_checked, n_clip;
	lrwm_out_t merged_due [$];

	function automatic int active_rank();
		if (rank_reg == 0)
			return 1;
		return (rank_reg > MAX_RANK) ? MAX_RANK : rank_reg;
	endfunction

	function automatic int active_cols();
		if (cols_reg == 0)
			return 1;
		return (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : cols_reg;
	endfunction

	function automatic int active_rows();
		return (rows_reg == 0) ? 1 : rows_reg;
	endfunction

	// round half up: floor((v + 2^(sh-1)) / 2^sh)
	function automatic longint round_off(input longint v, input int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic logic signed [VAL_W-1:0] clamp16(input longint v, output logic hit);
		hit = 1'b1;
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		hit = 1'b0;
		return v[15:0];
	endfunction

	task automatic set_register(input logic [1:0] idx, input logic [15:0] d);
		case (idx)
			CFG_RANK:  rank_reg = d[4:0];
			CFG_SCALE: scale_reg = d;
			CFG_COLS:  cols_reg = d[10:0];
			CFG_ROWS:  rows_reg = d;
			default: ;
		endcase
	endtask

	task automatic take_item(input lrwm_in_t it);
		longint v, acc;
		logic hit;
		lrwm_out_t res;
		int r, k, c;
		v = it.value;
		k = active_rank();
		c = active_cols();
		case (it.kind)
			KIND_B: begin
				b_mem[b_ptr % B_DEPTH] = it.value;
				b_ptr = (b_ptr + 1 >= k * c) ? 0 : b_ptr + 1;
			end
			KIND_A: begin
				// clip of the scaled A is silent
				a_cells[a_ptr % MAX_RANK] = clamp16(round_off(v * scale_reg, 8), hit);
				a_ptr = (a_ptr + 1 >= k) ? 0 : a_ptr + 1;
			end
			KIND_BASE: begin
				acc = v * 4096;
				for (r = 0; r < k; r++)
					acc += longint'(a_cells[r]) * longint'(b_mem[(r * c + col_pos) % B_DEPTH]);
				res.merged_weight = clamp16(round_off(acc, 12), hit);
				res.saturated = hit;
				res.row_end = (col_pos + 1 >= c);
				res.matrix_end = res.row_end && (row_pos + 1 >= active_rows());
				if (res.row_end) begin
					col_pos = 0;
					a_ptr = 0;
					if (res.matrix_end) begin
						row_pos = 0;
						b_ptr = 0;
					end else begin
						row_pos = (row_pos + 1) & 16'hffff;
					end
				end else begin
					col_pos = col_pos + 1;
				end
				merged_due.push_back(res);
			end
			default: ;
		endcase
	endtask

	task automatic check_result(input lrwm_out_t got);
		lrwm_out_t want;
		if (merged_due.size() == 0) begin
			$error("merged_weight %0d arrived with nothing expected", got.merged_weight);
			n_bad++;
		end else begin
			want = merged_due.pop_front();
			n_checked++;
			if (want.saturated)
				n_clip++;
			if (got.merged_weight !== want.merged_weight) begin
				$error("merged_weight: expected %0d, got %0d", want.merged_weight,
					got.merged_weight);
				n_bad++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
				n_bad++;
			end
			if (got.row_end !== want.row_end) begin
				$error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
				n_bad++;
			end
			if (got.matrix_end !== want.matrix_end) begin
				$error("matrix_end: expected %0d, got %0d", want.matrix_end, got.matrix_end);
				n_bad++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_ptr = 0;
			a_ptr = 0;
			col_pos = 0;
			row_pos = 0;
			rank_reg = 1;
			scale_reg = 256;
			cols_reg = MAX_COLUMNS;
			rows_reg = 1;
			merged_due.delete();
		end else begin
			if (out_valid && out_ready)
				check_result(out_data);
			if (cfg_valid && cfg_ready)
				set_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				take_item(in_data);
		end
		mismatches <= n_bad;
		outstanding <= merged_due.size();
		weights_checked <= n_checked;
		clipped_seen <= n_clip;
	end

endmodule

FILE: tb/tb_low_rank_weight_merge_core.sv
// Testbench top for the low-rank weight merge block: stimulus, back-pressure and verdict.
module tb_low_rank_weight_merge_core
	import lrwm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_RANK    = 16;
	localparam int MAX_COLUMNS = 1024;
	localparam int CLK_PERIOD  = 10;
	localparam int ITEMS       = 1700;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 32;
	localparam logic [1:0] KIND_NONE = 2'd3;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	lrwm_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	lrwm_out_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_RANK;
	logic [15:0] cfg_data = '0;

	int mismatches, outstanding, weights_checked, clipped_seen;
	int cycles = 0;
	int fed_items = 0;
	int settings_used = 0;
	logic quiet = 1'b0;
	logic hold_req = 1'b0;
	bit hold_done = 1'b0;

	low_rank_weight_merge_core #(
		.MAX_RANK(MAX_RANK),
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_dut (
		.clk, .arst_n,
		.in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	lrwm_merge_checker #(
		.MAX_RANK(MAX_RANK),
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_check (
		.clk, .arst_n,
		.in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.mismatches, .outstanding, .weights_checked, .clipped_seen
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_low_rank_weight_merge_core: FAIL");
			$finish;
		end
	end

	// receiver: short random stalls, one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return '0;
					default: return -16'sd1;
				endcase
			end
			1: return 16'(int'($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_item(input logic [1:0] k, input logic signed [VAL_W-1:0] v);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{kind: k, value: v};
		do @(posedge clk); while (!in_ready);
		if (k != KIND_NONE)
			fed_items++;
		quiet <= (fed_items >= ITEMS * 17 / 20);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_config(input int rk, input int sc, input int cl, input int rw);
		write_reg(CFG_RANK, 16'(rk));
		write_reg(CFG_SCALE, 16'(sc));
		write_reg(CFG_COLS, 16'(cl));
		write_reg(CFG_ROWS, 16'(rw));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// drop valid, wait for every merged weight, then let the pipeline run dry
	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic maybe_noise();
		case ($urandom_range(0, 23))
			0: send_item(KIND_NONE, pick_value());
			1: send_item(KIND_B, pick_value());
			2: send_item(KIND_A, pick_value());
			default: ;
		endcase
	endtask

	task automatic run_matrix(input int rk, input int sc, input int cl, input int rw,
			input bit hold);
		int er, ec, en, i, row, col, a_cnt;
		write_config(rk, sc, cl, rw);
		er = (rk == 0) ? 1 : ((rk > MAX_RANK) ? MAX_RANK : rk);
		ec = (cl == 0) ? 1 : ((cl > MAX_COLUMNS) ? MAX_COLUMNS : cl);
		en = (rw == 0) ? 1 : rw;
		for (i = 0; i < er * ec; i++)
			send_item(KIND_B, pick_value());
		for (row = 0; row < en; row++) begin
			a_cnt = er;
			if (row > 0 && $urandom_range(0, 7) == 0)
				a_cnt = $urandom_range(0, er + 3);
			for (i = 0; i < a_cnt; i++)
				send_item(KIND_A, pick_value());
			if (hold && row == 0)
				hold_req <= 1'b1;
			for (col = 0; col < ec; col++) begin
				maybe_noise();
				send_item(KIND_BASE, pick_value());
			end
		end
		settle_block();
	endtask

	// rank one over a row wider than the block holds, then the row cut short with the column count set to one
	task automatic run_wide_cut(input int sc);
		int n, i;
		n = $urandom_range(40, 120);
		write_config($urandom_range(0, 1), sc, $urandom_range(MAX_COLUMNS, 2047),
			$urandom_range(0, 1));
		for (i = 0; i <= n; i++)
			send_item(KIND_B, pick_value());
		send_item(KIND_A, pick_value());
		for (i = 0; i < n; i++)
			send_item(KIND_BASE, pick_value());
		settle_block();
		write_reg(CFG_COLS, 16'd1);
		cfg_valid <= 1'b0;
		settings_used++;
		send_item(KIND_BASE, pick_value());
		settle_block();
	endtask

	task automatic run_random_phase(input int phase_no);
		int rk, sc, cl, rw;
		bit hold, wide;
		hold = 1'b0;
		wide = 1'b0;
		rk = $urandom_range(1, MAX_RANK);
		case ($urandom_range(0, 9))
			0: rk = 0;
			1: rk = $urandom_range(MAX_RANK + 1, 31);
			default: ;
		endcase
		case ($urandom_range(0, 3))
			0: sc = $urandom_range(0, 512);
			1: sc = $urandom_range(0, 1) ? 65535 : 0;
			default: sc = $urandom_range(0, 65535);
		endcase
		cl = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
		rw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
		case (phase_no)
			0: begin
				rk = 31;
				sc = 65535;
				rw = 2;
			end
			1: hold = 1'b1;
			2: wide = 1'b1;
			default: ;
		endcase
		if (wide)
			run_wide_cut(sc);
		else
			run_matrix(rk, sc, cl, rw, hold);
	endtask

	initial begin
		int phase_no;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of values, rows at maximum, then limits cut mid-matrix
		write_config(2, 256, 4, 65535);
		send_item(KIND_B, 16'sh7fff);
		send_item(KIND_B, 16'sh8000);
		send_item(KIND_B, 16'sh0000);
		send_item(KIND_B, 16'sh0001);
		send_item(KIND_B, -16'sd1);
		send_item(KIND_B, 16'sh5555);
		send_item(KIND_B, 16'shaaaa);
		send_item(KIND_B, 16'sh1000);
		send_item(KIND_A, 16'sh7fff);
		send_item(KIND_A, 16'sh8000);
		send_item(KIND_BASE, 16'sh7fff);
		send_item(KIND_BASE, 16'sh8000);
		send_item(KIND_BASE, 16'sh0000);
		send_item(KIND_BASE, -16'sd1);
		send_item(KIND_A, 16'sh1000);
		send_item(KIND_A, -16'sh1000);
		send_item(KIND_BASE, 16'sh0001);
		send_item(KIND_BASE, 16'sh0002);
		settle_block();
		write_reg(CFG_COLS, 16'd1);
		write_reg(CFG_ROWS, 16'd2);
		cfg_valid <= 1'b0;
		settings_used++;
		send_item(KIND_BASE, 16'sd100);
		send_item(KIND_NONE, 16'sh7fff);
		settle_block();

		// zero rank, column and row registers act as one
		write_config(0, 0, 0, 0);
		send_item(KIND_B, 16'sh4000);
		send_item(KIND_A, 16'sh7fff);
		send_item(KIND_BASE, 16'sh8000);
		settle_block();

		phase_no = 0;
		while (fed_items < ITEMS) begin
			run_random_phase(phase_no);
			phase_no++;
		end

		$display("Covered %0d items over %0d register settings, incl. limits cut mid-matrix,",
			fed_items, settings_used);
		$display("a %0d-cycle output hold; %0d merged weights checked, %0d clipped.",
			LONG_HOLD, weights_checked, clipped_seen);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_low_rank_weight_merge_core: PASS");
		end else begin
			$display("tb_low_rank_weight_merge_core: FAIL");
		end
		$finish;
	end

endmodule
